@@ sv/rfs_pkg.sv @@
// ============================================================================
// rfs_pkg
// Shared types and constants of the recursive frame smoother: beat layouts of
// the pixel and result channels, blend weight constants, parameter defaults.
// ============================================================================
`default_nettype none

package rfs_pkg;

    // Field widths fixed by the channel definitions
    localparam int FIELD_W  = 16;
    localparam int WEIGHT_W = 17;

    // Q1.16 constants
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic [WEIGHT_W-1:0] ROUND_HALF = 17'd32768;
    localparam int                  FRAC_BITS  = 16;

    // Parameter defaults
    localparam int unsigned FRAME_PIXELS_DEF = 65536;
    localparam int unsigned PIXEL_BITS_DEF   = 16;

    // Input beat
    typedef struct packed {
        logic [FIELD_W-1:0] pixel_value;
        logic [FIELD_W-1:0] pixel_index;
        logic               first_frame;
    } t_rfs_in;

    // Output beat
    typedef struct packed {
        logic [FIELD_W-1:0] smoothed_value;
        logic [FIELD_W-1:0] out_index;
    } t_rfs_out;

endpackage

`default_nettype wire

@@ sv/recursive_frame_smoother.sv @@
// ============================================================================
// recursive_frame_smoother
// Per-pixel first-order recursive temporal filter over a stream of frames.
// The previous result of every frame position lives in a single frame store.
// ============================================================================
// Usage:
//   Pixel beats enter on i_in_valid / o_in_stall, results leave on
//   o_out_valid / i_out_stall. A beat moves when valid is high and stall low.
//   Each pixel gives one result: round(w*pixel + (1-w)*previous), with the
//   previous result of that position taken as zero when first_frame is set.
//   The blend weight (Q1.16, values above 1.0 clip to 1.0) is written over
//   i_cfg_valid / o_cfg_ready; the user must write it only while no pixel
//   is in flight, the block does not enforce this. One pixel per cycle is
//   sustained unless i_out_stall holds the output: the frame store does one
//   read and one write per cycle, and a result written in the same cycle as
//   the read of the same position is forwarded to the reader. A pixel passes
//   stage A, which reduces the index to a store address, then stage B, which
//   blends and writes back, into the output register for the result beat.
//   While the output beat waits under i_out_stall the whole pipeline holds
//   and o_in_stall is raised; a waiting result does not block intake
//   otherwise. Reset clears the pipeline valids and sets the weight to 1.0;
//   the store contents are unknown until a position is first written.
// ============================================================================
`default_nettype none

module recursive_frame_smoother
    import rfs_pkg::*;
#(
    parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF,
    parameter int unsigned PIXEL_BITS   = PIXEL_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // pixel channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_rfs_in             i_in_data,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_rfs_out                 o_out_data,
    // weight register
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [WEIGHT_W-1:0] i_cfg_data
);

    localparam int PB = PIXEL_BITS;
    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int DW = PB + 1;          // signed pixel difference
    localparam int PW = PB + 19;         // signed weighted difference
    // reciprocal of the frame size, 2^16 / FRAME_PIXELS
    localparam logic [WEIGHT_W-1:0] RECIP   = WEIGHT_W'(65536 / FRAME_PIXELS);
    localparam logic [FIELD_W-1:0]  FRM_LOW = FIELD_W'(FRAME_PIXELS % 65536);

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless the output beat is held
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic adv;
    logic in_acc;

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;
    assign in_acc     = i_in_valid && adv;

    // ------------------------------------------------------------------
    // Weight register, clipped to 1.0 on write
    // ------------------------------------------------------------------
    logic [WEIGHT_W-1:0] r_weight;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_ONE;
        end else if (i_cfg_valid) begin
            r_weight <= (i_cfg_data > WEIGHT_ONE) ? WEIGHT_ONE : i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input side: pixel masking and quotient estimate of index / frame
    // ------------------------------------------------------------------
    logic [PB+FIELD_W-1:0]         in_pix_ext;
    logic [PB-1:0]                 in_pix;
    logic [FIELD_W+WEIGHT_W-1:0]   in_qprod;

    assign in_pix_ext = {PB'(0), i_in_data.pixel_value};
    assign in_pix     = in_pix_ext[PB-1:0];
    assign in_qprod   = (FIELD_W+WEIGHT_W)'(i_in_data.pixel_index) *
                        (FIELD_W+WEIGHT_W)'(RECIP);

    // stage A registers
    logic                r_a_valid;
    logic [PB-1:0]       r_a_pix;
    logic [FIELD_W-1:0]  r_a_idx;
    logic                r_a_first;
    logic [FIELD_W-1:0]  r_a_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_pix   <= in_pix;
            r_a_idx   <= i_in_data.pixel_index;
            r_a_first <= i_in_data.first_frame;
            r_a_q     <= in_qprod[FRAC_BITS +: FIELD_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage A: remainder with one correction step gives the store address
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0]    a_qf;
    logic [FIELD_W-1:0]    a_rem;
    logic [FIELD_W-1:0]    a_mod;
    logic [AW+FIELD_W-1:0] a_addr_ext;
    logic [AW-1:0]         a_addr;

    assign a_qf       = FIELD_W'(r_a_q * FRM_LOW);
    assign a_rem      = r_a_idx - a_qf;
    assign a_mod      = (32'(a_rem) >= 32'(FRAME_PIXELS)) ? (a_rem - FRM_LOW) : a_rem;
    assign a_addr_ext = {AW'(0), a_mod};
    assign a_addr     = a_addr_ext[AW-1:0];

    // stage B registers
    logic                r_b_valid;
    logic [PB-1:0]       r_b_pix;
    logic [FIELD_W-1:0]  r_b_idx;
    logic                r_b_first;
    logic [AW-1:0]       r_b_addr;
    logic                r_fwd_hit;
    logic [PB-1:0]       r_fwd_data;
    logic [PB-1:0]       r_rd_data;
    logic [PB-1:0]       b_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    // forward the result being written when stage A reads the same position
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_pix    <= r_a_pix;
            r_b_idx    <= r_a_idx;
            r_b_first  <= r_a_first;
            r_b_addr   <= a_addr;
            r_fwd_hit  <= r_b_valid && (a_addr == r_b_addr);
            r_fwd_data <= b_result;
        end
    end

    // ------------------------------------------------------------------
    // Frame store: read in stage A, written back from stage B
    // ------------------------------------------------------------------
    logic [PB-1:0] mem [FRAME_PIXELS];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_data <= mem[a_addr];
            if (r_b_valid) begin
                mem[r_b_addr] <= b_result;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: prev + round(w * (pixel - prev))
    // ------------------------------------------------------------------
    logic [PB-1:0]        b_prev;
    logic signed [DW-1:0] b_diff;
    logic signed [PW-1:0] b_prod;
    logic signed [PW-1:0] b_step;
    logic signed [PW-1:0] b_sum;

    assign b_prev   = r_b_first ? PB'(0) : (r_fwd_hit ? r_fwd_data : r_rd_data);
    assign b_diff   = $signed({1'b0, r_b_pix}) - $signed({1'b0, b_prev});
    assign b_prod   = PW'($signed({1'b0, r_weight})) * PW'(b_diff)
                      + $signed(PW'(ROUND_HALF));
    assign b_step   = b_prod >>> FRAC_BITS;
    assign b_sum    = b_step + $signed(PW'(b_prev));
    assign b_result = b_sum[PB-1:0];

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PB+FIELD_W-1:0] b_res_ext;
    t_rfs_out              r_out_data;

    assign b_res_ext = {FIELD_W'(0), b_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_b_valid) begin
            r_out_data.smoothed_value <= b_res_ext[FIELD_W-1:0];
            r_out_data.out_index      <= r_b_idx;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hold_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("intake open while result beat is held");

    a_weight_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_weight <= WEIGHT_ONE)
        else $error("blend weight above 1.0");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (32'(a_mod) < 32'(FRAME_PIXELS)))
        else $error("store address outside the frame");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_a_valid)
        else $error("accepted pixel beat lost at stage A");

    a_forward_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_a_valid && r_b_valid && (a_addr == r_b_addr))
        |=> (r_fwd_hit && (r_fwd_data == $past(b_result))))
        else $error("same-position result not forwarded");

endmodule

`default_nettype wire

@@ dv/recursive_frame_smoother_tb.sv @@
// ============================================================================
// recursive_frame_smoother_tb
// Self-checking bench for the recursive frame smoother. Pixel beats come from
// a queue that the stimulus process fills. A clocked driver sends them with
// random gaps, and a clocked monitor stalls the result channel at random.
// Every accepted pixel is run through a local copy of the blend and of the
// frame history. Each result beat is compared field by field with the oldest
// prediction. The blend weight is rewritten between phases, only while the
// block is drained, and covers zero, one, above one and values in between.
// ============================================================================
`default_nettype none

module recursive_frame_smoother_tb
    import rfs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 56;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // DUT connections
    logic                in_valid  = 1'b0;
    logic                in_stall;
    t_rfs_in             in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_rfs_out            out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WEIGHT_W-1:0] cfg_data  = '0;

    recursive_frame_smoother uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // Stimulus and prediction state
    t_rfs_in             pixel_queue[$];
    t_rfs_out            expected_results[$];
    logic [WEIGHT_W-1:0] weight_queue[$];
    logic [WEIGHT_W-1:0] weight_model = WEIGHT_ONE;
    logic [FIELD_W-1:0]  frame_history[FRAME_PIXELS_DEF];
    bit                  index_written[FRAME_PIXELS_DEF];
    logic [FIELD_W-1:0]  recent_index[$];
    int                  pixels_queued   = 0;
    int                  pixels_accepted = 0;
    int                  weights_queued  = 0;
    int                  weights_written = 0;
    int                  fail_count      = 0;
    int                  cycle_count     = 0;
    int                  send_gap        = 0;
    int                  stall_left      = 0;
    bit                  no_gaps         = 1'b0;
    t_rfs_out            want;

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Blend one pixel with its stored history and update the history
    function automatic t_rfs_out blend_pixel(t_rfs_in px);
        logic [WEIGHT_W-1:0] w;
        logic [FIELD_W-1:0]  prev;
        logic [33:0]         acc;
        int unsigned         pos;
        t_rfs_out            r;
        w    = (weight_model > WEIGHT_ONE) ? WEIGHT_ONE : weight_model;
        pos  = px.pixel_index % FRAME_PIXELS_DEF;
        prev = px.first_frame ? '0 : frame_history[pos];
        acc  = 34'(w) * 34'(px.pixel_value) + 34'(WEIGHT_ONE - w) * 34'(prev)
             + 34'(ROUND_HALF);
        r.smoothed_value   = acc[FRAC_BITS +: FIELD_W];
        r.out_index        = px.pixel_index;
        frame_history[pos] = r.smoothed_value;
        return r;
    endfunction

    // Pixel driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_results.insert(expected_results.size(), blend_pixel(in_data));
                pixels_accepted++;
                send_gap = pick_idle();
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pixel_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Weight register writer
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                weight_model = cfg_data;
                weights_written++;
            end
            if (!cfg_valid || cfg_ready) begin
                if (weight_queue.size() > 0) begin
                    cfg_valid <= 1'b1;
                    cfg_data  <= weight_queue.pop_front();
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and random stall
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected, out_index %0d",
                           out_data.out_index);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.smoothed_value !== want.smoothed_value) begin
                        $error("smoothed_value: expected %0d, got %0d",
                               want.smoothed_value, out_data.smoothed_value);
                        fail_count++;
                    end
                    if (out_data.out_index !== want.out_index) begin
                        $error("out_index: expected %0d, got %0d",
                               want.out_index, out_data.out_index);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                stall_left = pick_idle();
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Queue one pixel; a later frame never lands on an unwritten position
    task automatic push_pixel(input logic [FIELD_W-1:0] value,
                              input logic [FIELD_W-1:0] index, input bit first);
        t_rfs_in px;
        px.pixel_value = value;
        px.pixel_index = index;
        px.first_frame = first || !index_written[index];
        index_written[index] = 1'b1;
        recent_index.insert(recent_index.size(), index);
        if (recent_index.size() > 64)
            void'(recent_index.pop_front());
        pixel_queue.insert(pixel_queue.size(), px);
        pixels_queued++;
    endtask

    function automatic logic [FIELD_W-1:0] rand_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return FIELD_W'($urandom);
    endfunction

    // A short run of frames over one set of positions
    task automatic push_frames();
        logic [FIELD_W-1:0] positions[$];
        int                 n_pos;
        int                 n_frames;
        n_pos    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                              : $urandom_range(1, 8);
        n_frames = $urandom_range(1, 6);
        for (int i = 0; i < n_pos; i++)
            positions.insert(positions.size(), FIELD_W'($urandom));
        for (int f = 0; f < n_frames; f++) begin
            for (int i = 0; i < n_pos; i++) begin
                // now and then a frame restarts partway through
                push_pixel(rand_pixel(), positions[i],
                           f == 0 || $urandom_range(0, 49) == 0);
            end
        end
    endtask

    // Stray pixels: fresh positions or revisits of recent ones
    task automatic push_noise();
        if (recent_index.size() > 0 && $urandom_range(0, 1) == 1)
            push_pixel(rand_pixel(),
                       recent_index[$urandom_range(0, recent_index.size() - 1)],
                       $urandom_range(0, 1));
        else
            push_pixel(rand_pixel(), FIELD_W'($urandom), 1'b1);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pixels_accepted != pixels_queued || expected_results.size() != 0);
    endtask

    // Weight changes only with the pipeline empty
    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        weight_queue.insert(weight_queue.size(), w);
        weights_queued++;
        do
            @(posedge clk);
        while (weights_written != weights_queued);
    endtask

    // Stimulus
    initial begin
        logic [WEIGHT_W-1:0] w;
        int                  target;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: weight of one after reset, field extremes, alternating bits
        push_pixel(16'h0000, 16'h0000, 1'b1);
        push_pixel(16'hFFFF, 16'hFFFF, 1'b1);
        push_pixel(16'h5555, 16'hAAAA, 1'b1);
        push_pixel(16'hAAAA, 16'h5555, 1'b1);
        push_pixel(16'd1234, 16'h0000, 1'b0);

        // Weight zero keeps the history
        write_weight('0);
        push_pixel(16'h0000, 16'hFFFF, 1'b0);
        push_pixel(16'hFFFF, 16'h0000, 1'b1);

        // Weight above one clips to one
        write_weight('1);
        push_pixel(16'd40000, 16'hAAAA, 1'b0);

        // Half weight: round half up
        write_weight(17'd32768);
        push_pixel(16'd1, 16'h0000, 1'b0);
        push_pixel(16'hFFFF, 16'h5555, 1'b0);
        push_pixel(16'd3, 16'h1234, 1'b1);
        // back-to-back hits on one position
        no_gaps = 1'b1;
        push_pixel(16'd1000, 16'h0007, 1'b1);
        push_pixel(16'd3000, 16'h0007, 1'b0);
        push_pixel(16'hFFFF, 16'h0007, 1'b0);
        push_pixel(16'd0, 16'h0007, 1'b0);

        // Smallest nonzero weight, then just above one
        write_weight(17'd1);
        no_gaps = 1'b0;
        push_pixel(16'hFFFF, 16'hFFFF, 1'b0);
        push_pixel(16'hFFFF, 16'h0000, 1'b0);
        write_weight(17'd65537);
        push_pixel(16'd777, 16'h1234, 1'b0);

        // Random phases, each under its own weight
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       w = WEIGHT_ONE;
                1:       w = '0;
                2:       w = 17'd65535;
                3:       w = 17'd32768;
                4:       w = '1;
                default: w = WEIGHT_W'($urandom_range(0, 131071));
            endcase
            write_weight(w);
            no_gaps = (ph == 2 || ph == 5);
            target  = pixels_queued + PHASE_ITEMS;
            while (pixels_queued < target) begin
                if ($urandom_range(0, 4) == 0)
                    push_noise();
                else
                    push_frames();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
